// ===== design/hjd_pkg.sv =====
`default_nettype none

package hjd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int SETTLE_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_JACK_ACTIVE_HIGH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_JACK_SETTLE_TICKS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SETTLE_TICKS  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_POLE_ENABLE  = 8'd3;

    localparam logic [SETTLE_W-1:0] RESET_JACK_SETTLE = 16'd300;
    localparam logic [SETTLE_W-1:0] RESET_KEY_SETTLE  = 16'd50;

    localparam logic [1:0] JACK_NONE      = 2'd0;
    localparam logic [1:0] JACK_THREE_POLE = 2'd1;
    localparam logic [1:0] JACK_FOUR_POLE  = 2'd2;

    localparam logic [1:0] KEY_NONE     = 2'd0;
    localparam logic [1:0] KEY_PRESSED  = 2'd1;
    localparam logic [1:0] KEY_RELEASED = 2'd2;

    localparam logic [1:0] PLUG_OUT     = 2'd0;
    localparam logic [1:0] PLUG_IN      = 2'd1;
    localparam logic [1:0] PLUG_UNKNOWN = 2'd2;

    typedef struct packed {
        logic                jack_active_high;
        logic [SETTLE_W-1:0] jack_settle_ticks;
        logic [SETTLE_W-1:0] key_settle_ticks;
        logic                four_pole_enable;
    } hjd_cfg_t;

    typedef struct packed {
        logic       type_changed;
        logic [1:0] key_event;
        logic       mic_bias;
        logic       audio_route;
        logic [1:0] jack_type;
    } hjd_result_t;

endpackage

`default_nettype wire

// ===== design/hjd_core.sv =====
`default_nettype none

module hjd_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  wire                  jack_pin,
    input  wire                  mic_pin,
    input  hjd_pkg::hjd_cfg_t    cfg,
    output hjd_pkg::hjd_result_t result
);
    import hjd_pkg::*;

    localparam logic [31:0] COUNT_MAX = 32'({TIMER_BITS{1'b1}});

    logic                  last_jack_pin_reg, last_jack_pin_next;
    logic                  last_mic_pin_reg, last_mic_pin_next;
    logic [TIMER_BITS-1:0] jack_count_reg, jack_count_next;
    logic [TIMER_BITS-1:0] key_count_reg, key_count_next;
    logic                  jack_first_reg, jack_first_next;
    logic                  key_first_reg, key_first_next;
    logic [1:0]            plug_state_reg, plug_state_next;
    logic [1:0]            kind_reg, kind_next;
    logic                  four_pole_reg, four_pole_next;
    logic                  key_ready_reg, key_ready_next;
    logic                  bias_reg, bias_next;
    logic                  route_reg, route_next;

    logic                  plugged;
    logic                  mic_present;
    logic [TIMER_BITS-1:0] jack_dec;
    logic [TIMER_BITS-1:0] key_dec;
    logic [TIMER_BITS-1:0] jack_load;
    logic [TIMER_BITS-1:0] key_load;
    logic [1:0]            key_event;
    logic                  changed;

    function automatic logic [TIMER_BITS-1:0] load_value(input logic [SETTLE_W-1:0] settle);
        logic [31:0] wide;
        begin
            wide = 32'(settle);
            if (wide == 32'd0)
            begin
                load_value = TIMER_BITS'(1);
            end
            else if (wide > COUNT_MAX)
            begin
                load_value = {TIMER_BITS{1'b1}};
            end
            else
            begin
                load_value = wide[TIMER_BITS-1:0];
            end
        end
    endfunction

    assign plugged     = cfg.jack_active_high ? jack_pin : ~jack_pin;
    assign mic_present = ~mic_pin;
    assign jack_dec    = jack_count_reg - TIMER_BITS'(1);
    assign key_dec     = key_count_reg - TIMER_BITS'(1);
    assign jack_load   = load_value(cfg.jack_settle_ticks);
    assign key_load    = load_value(cfg.key_settle_ticks);

    always_comb
    begin
        last_jack_pin_next = jack_pin;
        last_mic_pin_next  = mic_pin;
        jack_count_next    = jack_count_reg;
        key_count_next     = key_count_reg;
        jack_first_next    = jack_first_reg;
        key_first_next     = key_first_reg;
        plug_state_next    = plug_state_reg;
        kind_next          = kind_reg;
        four_pole_next     = four_pole_reg;
        key_ready_next     = key_ready_reg;
        bias_next          = bias_reg;
        route_next         = route_reg;
        key_event          = KEY_NONE;
        changed            = 1'b0;

        // jack channel
        if (jack_count_reg != '0)
        begin
            jack_count_next = jack_dec;
            if ((jack_dec == '0) && (plug_state_reg != {1'b0, plugged}))
            begin
                if (!plugged && !jack_first_reg)
                begin
                    plug_state_next = PLUG_OUT;
                    kind_next       = JACK_NONE;
                    four_pole_next  = 1'b0;
                    bias_next       = 1'b0;
                    route_next      = 1'b0;
                    changed         = 1'b1;
                end
                else if (plugged && jack_first_reg)
                begin
                    plug_state_next = PLUG_IN;
                    if (cfg.four_pole_enable && mic_present)
                    begin
                        kind_next      = JACK_FOUR_POLE;
                        four_pole_next = 1'b1;
                    end
                    else
                    begin
                        kind_next      = JACK_THREE_POLE;
                        four_pole_next = 1'b0;
                        bias_next      = 1'b0;
                    end
                    route_next = 1'b1;
                    changed    = 1'b1;
                end
            end
        end
        else if (jack_pin != last_jack_pin_reg)
        begin
            jack_first_next = plugged;
            key_ready_next  = 1'b0;
            bias_next       = plugged;
            jack_count_next = jack_load;
        end

        // key channel, sees the jack channel's updates of this tick
        if (key_count_reg != '0)
        begin
            key_count_next = key_dec;
            if ((key_dec == '0) && (mic_present == key_first_reg))
            begin
                if (!key_ready_next)
                begin
                    key_ready_next = 1'b1;
                end
                else if (four_pole_next)
                begin
                    key_event = mic_present ? KEY_RELEASED : KEY_PRESSED;
                end
            end
        end
        else if (cfg.four_pole_enable && (mic_pin != last_mic_pin_reg))
        begin
            key_first_next = mic_present;
            key_count_next = key_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_jack_pin_reg <= 1'b0;
            last_mic_pin_reg  <= 1'b0;
            jack_count_reg    <= '0;
            key_count_reg     <= '0;
            jack_first_reg    <= 1'b0;
            key_first_reg     <= 1'b0;
            plug_state_reg    <= PLUG_UNKNOWN;
            kind_reg          <= JACK_NONE;
            four_pole_reg     <= 1'b0;
            key_ready_reg     <= 1'b0;
            bias_reg          <= 1'b0;
            route_reg         <= 1'b0;
        end
        else if (step)
        begin
            last_jack_pin_reg <= last_jack_pin_next;
            last_mic_pin_reg  <= last_mic_pin_next;
            jack_count_reg    <= jack_count_next;
            key_count_reg     <= key_count_next;
            jack_first_reg    <= jack_first_next;
            key_first_reg     <= key_first_next;
            plug_state_reg    <= plug_state_next;
            kind_reg          <= kind_next;
            four_pole_reg     <= four_pole_next;
            key_ready_reg     <= key_ready_next;
            bias_reg          <= bias_next;
            route_reg         <= route_next;
        end
    end

    always_comb
    begin
        result.jack_type    = kind_next;
        result.audio_route  = route_next;
        result.mic_bias     = bias_next;
        result.key_event    = key_event;
        result.type_changed = changed;
    end

endmodule

`default_nettype wire

// ===== design/headset_jack_and_hook_key_detector.sv =====
`default_nettype none

// Headset jack and hook key detector. Each input word is one time tick carrying the
// sampled jack-detect pin (bit 0) and mic line pin (bit 1); every accepted word yields
// exactly one result word holding the headset type, audio route, mic bias, a hook key
// press/release event and a pulse marking a jack type update. A pin edge starts that
// pin's settle countdown (jack_settle_ticks or key_settle_ticks, zero acting as one) and
// the second sample is judged when it runs out. One word is taken every unstalled cycle;
// the result is in the output register the cycle after acceptance, with the whole tick
// update (both countdown decrements and compares) done in one pass from state registers.
// Configuration (index 0 jack_active_high, 1 jack_settle_ticks, 2 key_settle_ticks,
// 3 four_pole_enable) is always ready; users must write it only while idle (unchecked).
module headset_jack_and_hook_key_detector #(
    parameter int TIMER_BITS = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [7:0]                      s_tdata,   // jack_pin, mic_pin, zero pad
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [7:0]                      m_tdata,   // jack_type[1:0], audio_route,
                                                       // mic_bias, key_event[1:0],
                                                       // type_changed, zero pad
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [hjd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [hjd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hjd_pkg::*;

    hjd_cfg_t    cfg_reg;
    hjd_result_t result;
    logic        step;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jack_active_high  <= 1'b1;
            cfg_reg.jack_settle_ticks <= RESET_JACK_SETTLE;
            cfg_reg.key_settle_ticks  <= RESET_KEY_SETTLE;
            cfg_reg.four_pole_enable  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_JACK_ACTIVE_HIGH:  cfg_reg.jack_active_high  <= cfg_data[0];
                REG_JACK_SETTLE_TICKS: cfg_reg.jack_settle_ticks <= cfg_data;
                REG_KEY_SETTLE_TICKS:  cfg_reg.key_settle_ticks  <= cfg_data;
                REG_FOUR_POLE_ENABLE:  cfg_reg.four_pole_enable  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    hjd_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .jack_pin (s_tdata[0]),
        .mic_pin  (s_tdata[1]),
        .cfg      (cfg_reg),
        .result   (result)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata_reg <= {1'b0, result};
        end
    end

endmodule

`default_nettype wire
